@@ hw/rtl/bchj_pkg.sv @@
// Package for the bucket-chained hash join table.
// Holds sizes, payload structs, state encodings and the front-to-back queue entry.
// No dependencies.
package bchj_pkg;

	localparam int NUM_BUCKETS      = 1024;
	localparam int SLOTS_PER_BUCKET = 4;
	localparam int POOL_BUCKETS     = 1024;
	localparam int KEY_WIDTH        = 32;

	localparam int BKT_W   = $clog2(NUM_BUCKETS);
	localparam int POOL_W  = $clog2(POOL_BUCKETS);
	localparam int LINK_W  = $clog2(POOL_BUCKETS + 1);
	localparam int FILL_W  = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int SLOT_W  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
	localparam int CNT_W   = 14;
	localparam int CNT_MAX = (1 << CNT_W) - 1;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_HASH_MASK = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_BITS = 1'b1;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_PROBE  = 1'b1;

	typedef struct packed {
		logic        op;
		logic [31:0] key;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0] match_count;
		logic             status;
	} result_t;

	// classified item handed from front to back
	typedef struct packed {
		logic                 op;
		logic [KEY_WIDTH-1:0] key;
		logic [BKT_W-1:0]     bkt;
	} job_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HEAD,
		ST_POOL_RD,
		ST_POOL,
		ST_DONE
	} bstate_t;

endpackage

@@ hw/rtl/bchj_front.sv @@
// Front part of the hash join table: holds configuration, accepts items,
// computes bucket index and queues jobs for the back part. Uses bchj_pkg.
module bchj_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  bchj_pkg::item_t                 item,
	output logic                            busy,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bchj_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bchj_pkg::CFG_DAT_W-1:0]  cfg_data,
	output logic                            job_valid,
	output bchj_pkg::job_t                  job,
	input  logic                            job_pop
);
	import bchj_pkg::*;

	logic [9:0] hash_mask_q;
	logic [4:0] skip_bits_q;
	logic [BKT_W-1:0] bkt;
	logic [31:0] masked;
	// two-entry queue
	job_t q_q [2];
	logic [1:0] cnt_q;
	logic rd_q;
	logic push;

	assign cfg_ready = 1'b1;
	assign masked = item.key & {22'd0, hash_mask_q};
	assign bkt = BKT_W'(masked >> skip_bits_q);
	assign busy = (cnt_q == 2'd2);
	assign push = start && !busy;
	assign job_valid = (cnt_q != 2'd0);
	assign job = q_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_mask_q <= 10'd1023;
			skip_bits_q <= 5'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_HASH_MASK: hash_mask_q <= cfg_data;
				REG_SKIP_BITS: skip_bits_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q  <= 1'b0;
		end else begin
			if (job_pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, job_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			q_q[rd_q ^ (cnt_q != 2'd0)] <= '{op: item.op, key: item.key, bkt: bkt};
	end

endmodule

@@ hw/rtl/bchj_back.sv @@
// Back part of the hash join table: bucket memories, insert and chain walk.
// Uses bchj_pkg; takes jobs from bchj_front.
module bchj_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  bchj_pkg::job_t      job,
	output logic                job_pop,
	output logic                done,
	output bchj_pkg::result_t   result
);
	import bchj_pkg::*;

	// key memories: one row holds a whole bucket
	logic [SLOTS_PER_BUCKET*KEY_WIDTH-1:0] head_keys [NUM_BUCKETS];
	logic [SLOTS_PER_BUCKET*KEY_WIDTH-1:0] pool_keys [POOL_BUCKETS];
	// fill and link per bucket; head entries are cleared by a pass after reset
	logic [FILL_W-1:0] head_fill [NUM_BUCKETS];
	logic [LINK_W-1:0] head_link [NUM_BUCKETS];
	logic [FILL_W-1:0] pool_fill [POOL_BUCKETS];
	logic [LINK_W-1:0] pool_link [POOL_BUCKETS];
	logic [BKT_W-1:0]  clr_q;

	bstate_t state_q, state_d;
	job_t    job_q;
	logic [LINK_W-1:0] next_free_q;
	logic [LINK_W-1:0] lk_q;
	logic [CNT_W:0]    cnt_q;
	logic [SLOTS_PER_BUCKET*KEY_WIDTH-1:0] hrow_q, prow_q;
	logic [FILL_W-1:0] hfill_q, pfill_q;
	logic [LINK_W-1:0] hlink_q, plink_q;

	logic [FILL_W-1:0] hf;
	logic [LINK_W-1:0] hl;
	logic [POOL_W-1:0] pidx;
	logic [CNT_W:0] hits;
	logic [CNT_W:0] csum;
	logic [SLOTS_PER_BUCKET*KEY_WIDTH-1:0] row;
	logic [FILL_W-1:0] rfill;
	logic load, hwr_key, pwr_key, pwr_new, drop;
	logic [SLOT_W-1:0] wslot;

	assign hf   = hfill_q;
	assign hl   = hlink_q;
	assign pidx = POOL_W'(lk_q - LINK_W'(1));
	assign row   = (state_q == ST_HEAD) ? hrow_q : prow_q;
	assign rfill = (state_q == ST_HEAD) ? hf : pfill_q;

	always_comb begin
		hits = '0;
		for (int i = 0; i < SLOTS_PER_BUCKET; i++)
			if (FILL_W'(i) < rfill && row[i*KEY_WIDTH +: KEY_WIDTH] == job_q.key)
				hits = hits + (CNT_W+1)'(1);
	end
	assign csum = cnt_q + hits;

	always_comb begin
		state_d = state_q;
		load = 1'b0;
		job_pop = 1'b0;
		hwr_key = 1'b0;
		pwr_key = 1'b0;
		pwr_new = 1'b0;
		drop = 1'b0;
		wslot = '0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == BKT_W'(NUM_BUCKETS - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					load = 1'b1;
					state_d = ST_HEAD;
				end
			end
			ST_HEAD: begin
				if (job_q.op == OP_PROBE) begin
					state_d = (hl != '0) ? ST_POOL_RD : ST_DONE;
				end else if (hf < FILL_W'(SLOTS_PER_BUCKET)) begin
					hwr_key = 1'b1;
					wslot = SLOT_W'(hf);
					state_d = ST_DONE;
				end else if (hl != '0) begin
					state_d = ST_POOL_RD;
				end else if (next_free_q >= LINK_W'(POOL_BUCKETS)) begin
					drop = 1'b1;
					state_d = ST_DONE;
				end else begin
					pwr_new = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_POOL_RD: state_d = ST_POOL;
			ST_POOL: begin
				if (job_q.op == OP_PROBE) begin
					state_d = (plink_q != '0) ? ST_POOL_RD : ST_DONE;
				end else if (pfill_q < FILL_W'(SLOTS_PER_BUCKET)) begin
					pwr_key = 1'b1;
					wslot = SLOT_W'(pfill_q);
					state_d = ST_DONE;
				end else if (next_free_q >= LINK_W'(POOL_BUCKETS)) begin
					drop = 1'b1;
					state_d = ST_DONE;
				end else begin
					pwr_new = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			next_free_q <= '0;
			done        <= 1'b0;
			result      <= '0;
		end else begin
			state_q <= state_d;
			done    <= 1'b0;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + BKT_W'(1);
			if (pwr_new)
				next_free_q <= next_free_q + LINK_W'(1);
			if (state_d == ST_DONE && state_q != ST_DONE) begin
				done <= 1'b1;
				result.status <= drop;
				result.match_count <= (job_q.op == OP_PROBE) ?
					((csum > (CNT_W+1)'(CNT_MAX)) ? CNT_W'(CNT_MAX) : csum[CNT_W-1:0]) :
					'0;
			end
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= job;
			cnt_q <= '0;
		end else if (state_q == ST_HEAD) begin
			cnt_q <= csum;
			lk_q  <= hl;
		end else if (state_q == ST_POOL) begin
			cnt_q <= csum;
			lk_q  <= plink_q;
		end
	end

	// head bucket memory: cleared after reset, read in the load cycle, written at insert
	always_ff @(posedge clk) begin
		if (load) begin
			hrow_q  <= head_keys[job.bkt];
			hfill_q <= head_fill[job.bkt];
			hlink_q <= head_link[job.bkt];
		end
		if (state_q == ST_CLEAR) begin
			head_fill[clr_q] <= '0;
			head_link[clr_q] <= '0;
		end else if (hwr_key) begin
			head_keys[job_q.bkt][wslot*KEY_WIDTH +: KEY_WIDTH] <= job_q.key;
			head_fill[job_q.bkt] <= hf + FILL_W'(1);
			head_link[job_q.bkt] <= hl;
		end else if (pwr_new) begin
			head_fill[job_q.bkt] <= hf;
			head_link[job_q.bkt] <= next_free_q + LINK_W'(1);
		end
	end

	// pool memory: read one bucket per visit, written at insert
	always_ff @(posedge clk) begin
		if (state_q == ST_POOL_RD) begin
			prow_q  <= pool_keys[pidx];
			pfill_q <= pool_fill[pidx];
			plink_q <= pool_link[pidx];
		end
		if (pwr_key) begin
			pool_keys[pidx][wslot*KEY_WIDTH +: KEY_WIDTH] <= job_q.key;
			pool_fill[pidx] <= pfill_q + FILL_W'(1);
		end else if (pwr_new) begin
			pool_keys[POOL_W'(next_free_q)][KEY_WIDTH-1:0] <= job_q.key;
			pool_fill[POOL_W'(next_free_q)] <= FILL_W'(1);
			pool_link[POOL_W'(next_free_q)] <= (state_q == ST_HEAD) ? hl : lk_q;
		end
	end

endmodule

@@ hw/rtl/bucket_chained_hash_join_table.sv @@
// Bucket-chained hash join table, keys only. Uses bchj_pkg, bchj_front, bchj_back.
// Insert visits the head bucket and at most the first pool bucket of its chain; probe visits
// the head and every pool bucket in the chain, with one memory read per pool bucket visit in the back part.
// The back part finishes one item before it takes the next; a two-entry queue
// lets the front take items meanwhile.
// Reset clears pool counter and registers; the back part then clears every head
// fill and link while items queue. The receiver cannot stall.
module bucket_chained_hash_join_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  bchj_pkg::item_t                 item,
	output logic                            busy,
	output logic                            done,
	output bchj_pkg::result_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bchj_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bchj_pkg::CFG_DAT_W-1:0]  cfg_data
);
	import bchj_pkg::*;

	logic job_valid, job_pop;
	job_t job;

	bchj_front u_front (
		.clk, .arst_n, .start, .item, .busy,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.job_valid, .job, .job_pop
	);

	bchj_back u_back (
		.clk, .arst_n, .job_valid, .job, .job_pop, .done, .result
	);

	a_drop_is_insert: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status |-> result.match_count == '0)
		else $error("drop flagged with nonzero count");
	a_pop_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid)
		else $error("back part popped an empty queue");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

endmodule
